@@ rtl/minimum_spanning_tree_kruskal_defines.svh @@
// Assertion macros for the minimum spanning tree block.
// Included by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef MINIMUM_SPANNING_TREE_KRUSKAL_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_KRUSKAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MSTK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MSTK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSTK_ASSERT_IMP(lbl, ante, cons, msg)
`define MSTK_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/mstk_pkg.sv @@
// Types and fixed widths shared by the spanning tree block and its interfaces.
// No dependencies.
package mstk_pkg;
  localparam int unsigned VC_W = 6;
  localparam int unsigned VID_W = 5;
  localparam int unsigned WEIGHT_W = 16;

  typedef struct packed {
    logic [VID_W-1:0]    edge_src;
    logic [VID_W-1:0]    edge_dest;
    logic [WEIGHT_W-1:0] edge_weight;
    logic                final_edge;
  } edge_word_t;

  typedef struct packed {
    logic [VID_W-1:0]    tree_src;
    logic [VID_W-1:0]    tree_dest;
    logic [WEIGHT_W-1:0] tree_weight;
    logic                edge_valid;
    logic                spanning;
    logic                dropped;
    logic                end_of_tree;
  } tree_word_t;
endpackage

@@ rtl/mstk_intf.sv @@
// Valid/ready channels for edge input words and tree result words.
// Depends on mstk_pkg.
interface mstk_edge_if;
  logic                   valid;
  logic                   ready;
  mstk_pkg::edge_word_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mstk_tree_if;
  logic                   valid;
  logic                   ready;
  mstk_pkg::tree_word_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/minimum_spanning_tree_kruskal.sv @@
// Channel     Dir  Word
// edge_i      in   edge_src, edge_dest, edge_weight, final_edge
// tree_o      out  tree_src, tree_dest, tree_weight, flags
// vertex_cnt  in   write enable and 6-bit vertex count
// Edges are loaded back to back. A solve over E stored edges makes up to E+1
// selection passes over the edge memory; each pass that finds an in-range edge
// is followed by two root walks on the root memory and two or three root memory
// writes. Results then leave one word at a time, each held until it is taken.
// Reset is asynchronous and needs no clearing pass. Edges are taken only while
// no solve is running.
// Depends on mstk_pkg, mstk_intf and minimum_spanning_tree_kruskal_defines.svh.
`include "minimum_spanning_tree_kruskal_defines.svh"
module minimum_spanning_tree_kruskal #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned MAX_EDGES    = 256,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vertex_count_we_i,
  input  logic [mstk_pkg::VC_W-1:0] vertex_count_i,
  mstk_edge_if.sink                 edge_i,
  mstk_tree_if.source               tree_o
);
  import mstk_pkg::*;

  localparam int unsigned VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned NW   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ETW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned KEYW = WEIGHT_BITS + EIW;

  typedef struct packed {
    logic [VID_W-1:0]       src;
    logic [VID_W-1:0]       dest;
    logic [WEIGHT_BITS-1:0] weight;
  } entry_t;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_NEXT      = 12'b000000000010,
    S_SEL       = 12'b000000000100,
    S_WALK_A    = 12'b000000001000,
    S_WALK_B    = 12'b000000010000,
    S_WR_SRC    = 12'b000000100000,
    S_WR_DST    = 12'b000001000000,
    S_WR_LINK   = 12'b000010000000,
    S_OUT_START = 12'b000100000000,
    S_OUT_RD    = 12'b001000000000,
    S_OUT_LD    = 12'b010000000000,
    S_OUT_WAIT  = 12'b100000000000
  } state_e;

  state_e            state_q, state_d;
  logic [VC_W-1:0]   vc_q;
  logic [ETW-1:0]    total_q, total_d;
  logic              drop_q, drop_d;
  logic [VW-1:0]     k_q, k_d;
  logic [VW-1:0]     j_q, j_d;
  logic [ETW-1:0]    issue_q, issue_d;
  logic              pv_q, pv_d;
  logic [EIW-1:0]    pidx_q;
  logic              found_q, found_d;
  logic [KEYW-1:0]   best_key_q, best_key_d;
  entry_t            best_q, best_d;
  logic [KEYW-1:0]   last_key_q, last_key_d;
  logic              have_last_q, have_last_d;
  logic [VW-1:0]     raddr_q, raddr_d;
  logic [VW-1:0]     ra_q, ra_d, rb_q, rb_d;
  logic [MAX_VERTICES-1:0] vld_q, vld_d;
  tree_word_t        out_q, out_d;
  logic              out_valid_q, out_valid_d;

  entry_t            edge_mem [MAX_EDGES];
  entry_t            ed_rd_q;
  logic [VW-1:0]     root_mem [MAX_VERTICES];
  logic [VW-1:0]     root_rd_q;
  entry_t            res_mem [MAX_VERTICES];
  entry_t            res_rd_q;

  logic [NW-1:0]     n_eff;
  logic              load_acc, load_ok;
  entry_t            load_ent;
  logic [KEYW-1:0]   cand_key;
  logic [VW-1:0]     root_val;
  logic              rt_we;
  logic [VW-1:0]     rt_waddr, rt_wdata;
  logic              spanning;

  always_comb begin
    if (vc_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(vc_q) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vc_q);
    end
  end

  assign edge_i.ready = (state_q == S_IDLE);
  assign load_acc     = edge_i.valid && edge_i.ready;
  assign load_ok      = (32'(edge_i.data.edge_src) < 32'(n_eff))
                     && (32'(edge_i.data.edge_dest) < 32'(n_eff))
                     && (32'(total_q) < MAX_EDGES);
  assign load_ent     = '{src: edge_i.data.edge_src, dest: edge_i.data.edge_dest,
                          weight: WEIGHT_BITS'(edge_i.data.edge_weight)};
  assign cand_key     = {ed_rd_q.weight, pidx_q};
  assign root_val     = vld_q[raddr_q] ? root_rd_q : raddr_q;
  assign spanning     = (32'(k_q) + 32'd1) == 32'(n_eff);
  assign tree_o.valid = out_valid_q;
  assign tree_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    drop_d      = drop_q;
    k_d         = k_q;
    j_d         = j_q;
    issue_d     = issue_q;
    pv_d        = 1'b0;
    found_d     = found_q;
    best_key_d  = best_key_q;
    best_d      = best_q;
    last_key_d  = last_key_q;
    have_last_d = have_last_q;
    raddr_d     = raddr_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    vld_d       = vld_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rt_we       = 1'b0;
    rt_waddr    = raddr_q;
    rt_wdata    = ra_q;
    case (state_q)
      S_IDLE: begin
        if (load_acc) begin
          if (load_ok) begin
            total_d = total_q + ETW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (edge_i.data.final_edge) begin
            vld_d       = '0;
            have_last_d = 1'b0;
            k_d         = '0;
            state_d     = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if ((32'(k_q) + 32'd1) >= 32'(n_eff)) begin
          state_d = S_OUT_START;
        end else begin
          issue_d = '0;
          found_d = 1'b0;
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        if (issue_q < total_q) begin
          pv_d    = 1'b1;
          issue_d = issue_q + ETW'(1);
        end
        if (pv_q) begin
          if ((!have_last_q || cand_key > last_key_q)
              && (!found_q || cand_key < best_key_q)) begin
            found_d    = 1'b1;
            best_key_d = cand_key;
            best_d     = ed_rd_q;
          end
        end else if (issue_q == total_q) begin
          if (!found_q) begin
            state_d = S_OUT_START;
          end else begin
            last_key_d  = best_key_q;
            have_last_d = 1'b1;
            if ((32'(best_q.src) >= 32'(n_eff)) || (32'(best_q.dest) >= 32'(n_eff))) begin
              drop_d  = 1'b1;
              state_d = S_NEXT;
            end else begin
              raddr_d = VW'(best_q.src);
              state_d = S_WALK_A;
            end
          end
        end
      end
      S_WALK_A: begin
        if (root_val == raddr_q) begin
          ra_d    = root_val;
          raddr_d = VW'(best_q.dest);
          state_d = S_WALK_B;
        end else begin
          raddr_d = root_val;
        end
      end
      S_WALK_B: begin
        if (root_val == raddr_q) begin
          rb_d    = root_val;
          state_d = S_WR_SRC;
        end else begin
          raddr_d = root_val;
        end
      end
      S_WR_SRC: begin
        rt_we    = 1'b1;
        rt_waddr = VW'(best_q.src);
        rt_wdata = ra_q;
        vld_d[rt_waddr] = 1'b1;
        state_d  = S_WR_DST;
      end
      S_WR_DST: begin
        rt_we    = 1'b1;
        rt_waddr = VW'(best_q.dest);
        rt_wdata = rb_q;
        vld_d[rt_waddr] = 1'b1;
        state_d  = (ra_q != rb_q) ? S_WR_LINK : S_NEXT;
      end
      S_WR_LINK: begin
        rt_we    = 1'b1;
        rt_waddr = rb_q;
        rt_wdata = ra_q;
        vld_d[rt_waddr] = 1'b1;
        k_d      = k_q + VW'(1);
        state_d  = S_NEXT;
      end
      S_OUT_START: begin
        j_d = '0;
        if (k_q == '0) begin
          out_d       = '{tree_src: '0, tree_dest: '0, tree_weight: '0,
                          edge_valid: 1'b0, spanning: spanning, dropped: drop_q,
                          end_of_tree: 1'b1};
          out_valid_d = 1'b1;
          state_d     = S_OUT_WAIT;
        end else begin
          state_d = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        out_d       = '{tree_src: res_rd_q.src, tree_dest: res_rd_q.dest,
                        tree_weight: WEIGHT_W'(res_rd_q.weight), edge_valid: 1'b1,
                        spanning: spanning, dropped: drop_q,
                        end_of_tree: (j_q == (k_q - VW'(1)))};
        out_valid_d = 1'b1;
        state_d     = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (tree_o.ready) begin
          out_valid_d = 1'b0;
          if (out_q.end_of_tree) begin
            total_d = '0;
            drop_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            j_d     = j_q + VW'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vc_q        <= VC_W'(32);
      total_q     <= '0;
      drop_q      <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
      issue_q     <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      have_last_q <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (vertex_count_we_i) begin
        vc_q <= vertex_count_i;
      end
      total_q     <= total_d;
      drop_q      <= drop_d;
      k_q         <= k_d;
      j_q         <= j_d;
      issue_q     <= issue_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      have_last_q <= have_last_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= EIW'(issue_q);
    best_key_q <= best_key_d;
    best_q     <= best_d;
    last_key_q <= last_key_d;
    raddr_q    <= raddr_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_acc && load_ok) begin
      edge_mem[EIW'(total_q)] <= load_ent;
    end
    ed_rd_q <= edge_mem[EIW'(issue_q)];
  end

  always_ff @(posedge clk_i) begin
    if (rt_we) begin
      root_mem[rt_waddr] <= rt_wdata;
    end
    root_rd_q <= root_mem[raddr_d];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WR_LINK) begin
      res_mem[k_q] <= best_q;
    end
    res_rd_q <= res_mem[j_q];
  end

  `MSTK_ASSERT_IMP(a_no_load_while_out, edge_i.ready, !tree_o.valid, "edge taken during output")
  `MSTK_ASSERT_IMP(a_tree_bound, state_q != S_IDLE, (32'(k_q) + 32'd1) <= 32'(n_eff), "too many tree edges")
  `MSTK_ASSERT_NXT(a_idle_after_end, tree_o.valid && tree_o.ready && tree_o.data.end_of_tree,
                   edge_i.ready && !tree_o.valid, "block not idle after last result")
endmodule
